[rtl/core/dll_pkg.sv]
// Package for the doubly linked list engine: payload word types, opcode,
// status and controller action codes. No dependencies.
`timescale 1ns / 1ps
package dll_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned HW       = 6;   // bits of a node handle
  localparam int unsigned LW       = 7;   // bits of a link (handle or none)
  localparam int unsigned DW       = 32;

  localparam logic [LW-1:0] NONE    = LW'(CAPACITY);
  localparam logic [LW-1:0] CAP_LNK = LW'(CAPACITY);

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_DELETE     = 3'd2;
  localparam logic [2:0] OP_CLEAR      = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_BADH  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic [3:0] A_NONE   = 4'd0;
  localparam logic [3:0] A_LOAD   = 4'd1;
  localparam logic [3:0] A_FULL   = 4'd2;
  localparam logic [3:0] A_BADH   = 4'd3;
  localparam logic [3:0] A_CLEAR  = 4'd4;
  localparam logic [3:0] A_EMPTY  = 4'd5;
  localparam logic [3:0] A_ALLOC  = 4'd6;
  localparam logic [3:0] A_LINK   = 4'd7;
  localparam logic [3:0] A_UNLINK = 4'd8;
  localparam logic [3:0] A_FREE   = 4'd9;
  localparam logic [3:0] A_RDSTEP = 4'd10;

  typedef struct packed {
    logic [2:0]           opcode;
    logic signed [DW-1:0] value;
    logic [HW-1:0]        handle;
  } dll_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [HW-1:0]        node_handle;
    logic signed [DW-1:0] node_value;
    logic [LW-1:0]        head_handle;
    logic [LW-1:0]        tail_handle;
    logic [LW-1:0]        element_count;
    logic                 last_result;
  } dll_out_t;

  typedef struct packed {
    logic [3:0] action;
  } dll_cmd_t;

  typedef struct packed {
    logic full;
    logic handle_ok;
    logic empty;
    logic walk_last;
  } dll_sts_t;

endpackage

[rtl/core/dll_ctrl.sv]
// Controller state machine of the list engine. Sequences each operation
// into datapath actions. Depends on dll_pkg.
`timescale 1ns / 1ps
module dll_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        opcode,
  input  dll_pkg::dll_sts_t sts,
  output dll_pkg::dll_cmd_t cmd,
  output logic              busy
);
  import dll_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_LINK  = 3'd2;
  localparam logic [2:0] S_UNL   = 3'd3;
  localparam logic [2:0] S_FREE  = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;

  logic [2:0] state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.action = A_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (sts.full) begin
                cmd.action = A_FULL;
              end else begin
                cmd.action = A_LOAD;
                state_next = S_ALLOC;
              end
            end
            OP_DELETE: begin
              if (!sts.handle_ok) begin
                cmd.action = A_BADH;
              end else begin
                cmd.action = A_LOAD;
                state_next = S_UNL;
              end
            end
            OP_CLEAR: cmd.action = A_CLEAR;
            OP_READ: begin
              if (sts.empty) begin
                cmd.action = A_EMPTY;
              end else begin
                cmd.action = A_LOAD;
                state_next = S_RD;
              end
            end
            default: cmd.action = A_NONE;
          endcase
        end
      end
      S_ALLOC: begin
        cmd.action = A_ALLOC;
        state_next = S_LINK;
      end
      S_LINK: begin
        cmd.action = A_LINK;
        state_next = S_IDLE;
      end
      S_UNL: begin
        cmd.action = A_UNLINK;
        state_next = S_FREE;
      end
      S_FREE: begin
        cmd.action = A_FREE;
        state_next = S_IDLE;
      end
      S_RD: begin
        cmd.action = A_RDSTEP;
        if (sts.walk_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

[rtl/core/dll_dp.sv]
// Datapath of the list engine: node memories, list registers, allocator
// and the registered result word. Depends on dll_pkg.
`timescale 1ns / 1ps
module dll_dp (
  input  logic              clk,
  input  logic              rst,
  input  dll_pkg::dll_cmd_t cmd,
  input  dll_pkg::dll_in_t  req,
  output dll_pkg::dll_sts_t sts,
  output dll_pkg::dll_out_t result,
  output logic              result_valid
);
  import dll_pkg::*;

  logic signed [DW-1:0] value_mem [CAPACITY];
  logic [LW-1:0]        next_mem  [CAPACITY];
  logic [LW-1:0]        prev_mem  [CAPACITY];

  logic signed [DW-1:0] rd_val;
  logic [LW-1:0]        rd_next, rd_prev;
  logic [HW-1:0]        raddr;

  logic                 vs_we, nx_we, pv_we;
  logic [HW-1:0]        vs_wa, nx_wa, pv_wa;
  logic signed [DW-1:0] vs_wd;
  logic [LW-1:0]        nx_wd, pv_wd;

  logic [CAPACITY-1:0]  in_use, in_use_next;
  logic [LW-1:0]        first, first_next, final_n, final_next;
  logic [LW-1:0]        count, count_next, fresh, fresh_next;
  logic [LW-1:0]        free_head, free_head_next;
  logic                 front, front_next;
  logic signed [DW-1:0] val_q, val_q_next;
  logic [HW-1:0]        h_q, h_q_next, cur, cur_next;
  logic [HW-1:0]        k, k_next;
  logic                 emit;
  logic [1:0]           r_status;
  logic [HW-1:0]        r_handle;
  logic signed [DW-1:0] r_value;
  logic                 r_last;
  logic [HW-1:0]        alloc_h;

  assign sts.full      = (free_head == NONE) && (fresh == CAP_LNK);
  assign sts.handle_ok = in_use[req.handle];
  assign sts.empty     = (first == NONE);
  assign sts.walk_last = (rd_next >= CAP_LNK) || (k == {HW{1'b1}});

  assign alloc_h = (free_head != NONE) ? free_head[HW-1:0] : fresh[HW-1:0];

  always_comb begin
    raddr = h_q;
    case (cmd.action)
      A_LOAD: begin
        case (req.opcode)
          OP_DELETE: raddr = req.handle;
          OP_READ:   raddr = first[HW-1:0];
          default:   raddr = free_head[HW-1:0];
        endcase
      end
      A_RDSTEP: raddr = rd_next[HW-1:0];
      default:  raddr = h_q;
    endcase
  end

  always_comb begin
    vs_we = 1'b0; vs_wa = h_q; vs_wd = val_q;
    nx_we = 1'b0; nx_wa = h_q; nx_wd = NONE;
    pv_we = 1'b0; pv_wa = h_q; pv_wd = NONE;
    in_use_next    = in_use;
    first_next     = first;
    final_next     = final_n;
    count_next     = count;
    fresh_next     = fresh;
    free_head_next = free_head;
    front_next     = front;
    val_q_next     = val_q;
    h_q_next       = h_q;
    cur_next       = cur;
    k_next         = k;
    emit           = 1'b0;
    r_status       = ST_OK;
    r_handle       = '0;
    r_value        = '0;
    r_last         = 1'b1;
    case (cmd.action)
      A_LOAD: begin
        front_next = (req.opcode == OP_PUSH_FRONT);
        val_q_next = req.value;
        h_q_next   = req.handle;
        cur_next   = first[HW-1:0];
        k_next     = '0;
      end
      A_FULL: begin
        emit = 1'b1; r_status = ST_FULL;
      end
      A_BADH: begin
        emit = 1'b1; r_status = ST_BADH; r_handle = req.handle;
      end
      A_EMPTY: begin
        emit = 1'b1; r_status = ST_EMPTY;
      end
      A_CLEAR: begin
        emit           = 1'b1;
        in_use_next    = '0;
        first_next     = NONE;
        final_next     = NONE;
        count_next     = '0;
        fresh_next     = '0;
        free_head_next = NONE;
      end
      A_ALLOC: begin
        h_q_next = alloc_h;
        if (free_head != NONE) free_head_next = rd_next;
        else                   fresh_next     = fresh + LW'(1);
        vs_we = 1'b1; vs_wa = alloc_h; vs_wd = val_q;
        nx_we = 1'b1; nx_wa = alloc_h; nx_wd = front ? first : NONE;
        pv_we = 1'b1; pv_wa = alloc_h; pv_wd = front ? NONE : final_n;
      end
      A_LINK: begin
        if (front) begin
          if (first != NONE) begin
            pv_we = 1'b1; pv_wa = first[HW-1:0]; pv_wd = {1'b0, h_q};
          end else begin
            final_next = {1'b0, h_q};
          end
          first_next = {1'b0, h_q};
        end else begin
          if (final_n != NONE) begin
            nx_we = 1'b1; nx_wa = final_n[HW-1:0]; nx_wd = {1'b0, h_q};
          end else begin
            first_next = {1'b0, h_q};
          end
          final_next = {1'b0, h_q};
        end
        in_use_next[h_q] = 1'b1;
        count_next = count + LW'(1);
        emit = 1'b1; r_handle = h_q; r_value = val_q;
      end
      A_UNLINK: begin
        if (rd_prev != NONE) begin
          nx_we = 1'b1; nx_wa = rd_prev[HW-1:0]; nx_wd = rd_next;
        end else begin
          first_next = rd_next;
        end
        if (rd_next != NONE) begin
          pv_we = 1'b1; pv_wa = rd_next[HW-1:0]; pv_wd = rd_prev;
        end else begin
          final_next = rd_prev;
        end
        in_use_next[h_q] = 1'b0;
        if (count != '0) count_next = count - LW'(1);
        val_q_next = rd_val;
      end
      A_FREE: begin
        nx_we = 1'b1; nx_wa = h_q; nx_wd = free_head;
        free_head_next   = {1'b0, h_q};
        emit = 1'b1; r_handle = h_q; r_value = val_q;
      end
      A_RDSTEP: begin
        cur_next = rd_next[HW-1:0];
        k_next   = k + HW'(1);
        emit = 1'b1; r_handle = cur; r_value = rd_val; r_last = sts.walk_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_val  <= value_mem[raddr];
    rd_next <= next_mem[raddr];
    rd_prev <= prev_mem[raddr];
    if (vs_we) value_mem[vs_wa] <= vs_wd;
    if (nx_we) next_mem[nx_wa]  <= nx_wd;
    if (pv_we) prev_mem[pv_wa]  <= pv_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use       <= '0;
      first        <= NONE;
      final_n      <= NONE;
      count        <= '0;
      fresh        <= '0;
      free_head    <= NONE;
      result_valid <= 1'b0;
    end else begin
      in_use       <= in_use_next;
      first        <= first_next;
      final_n      <= final_next;
      count        <= count_next;
      fresh        <= fresh_next;
      free_head    <= free_head_next;
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    front <= front_next;
    val_q <= val_q_next;
    h_q   <= h_q_next;
    cur   <= cur_next;
    k     <= k_next;
    if (emit) begin
      result.status        <= r_status;
      result.node_handle   <= r_handle;
      result.node_value    <= r_value;
      result.head_handle   <= first_next;
      result.tail_handle   <= final_next;
      result.element_count <= count_next;
      result.last_result   <= r_last;
    end
  end

  // The count always equals the number of nodes marked in use.
  a_count_pop: assert property (@(posedge clk) disable iff (rst)
    $countones(in_use) == 32'(count))
    else $error("node count differs from in-use population");

  // An empty head and a zero count go together.
  a_head_count: assert property (@(posedge clk) disable iff (rst)
    (first == NONE) == (count == '0))
    else $error("head and count disagree");

  // Head and tail are either both absent or both present.
  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    (first == NONE) == (final_n == NONE))
    else $error("head and tail disagree");

endmodule

[rtl/core/doubly_linked_list_engine_core.sv]
// Top level of the doubly linked list engine: joins the controller and the
// datapath. Depends on dll_pkg, dll_ctrl and dll_dp.
`timescale 1ns / 1ps
// The engine keeps a bounded doubly linked list of up to 64 nodes, each
// holding a 32-bit signed value. A command word is taken when start is high
// and busy is low; opcodes are push front, push back, delete by handle,
// clear and read. Every result word appears on result for exactly one cycle
// with result_valid high, and the receiver must take it then, as there is
// no way to hold results off. Push fetches the free-chain link, writes the
// new node and then relinks its neighbour; delete fetches the links,
// relinks the neighbours and returns the node to the free chain, while
// clear, a full pool, a bad handle and a read of an empty list answer the
// cycle after acceptance. A read walk gives one word per element per cycle
// after it fetches the head, limited by the single read port of the link
// memory, and marks the final word with last_result. Opcodes five to seven
// are taken and give no result. Every word reports the head, the tail and
// the count after the operation; a head or tail of 64 means the list is
// empty.
module doubly_linked_list_engine_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dll_pkg::dll_in_t  request,
  output logic              busy,
  output logic              result_valid,
  output dll_pkg::dll_out_t result
);
  import dll_pkg::*;

  dll_cmd_t cmd;
  dll_sts_t sts;

  // Of the request the controller sees only the opcode; the datapath does the work.
  dll_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (request.opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Node memories, list registers and the result register live here.
  dll_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req          (request),
    .sts          (sts),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule
